[rtl/emc_pkg.sv]
`default_nettype none

package emc_pkg;

  // Number of reference entries, one per cell of the compare chain.
  localparam int REF_DEPTH = 256;
  localparam int CNT_W     = $clog2(REF_DEPTH + 1);
  localparam int TOTAL_W   = 16;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_QUERY  = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef struct packed {
    logic [15:0]       target;
    logic [7:0]        delay;
    logic signed [1:0] sign;
  } entry_t;

  // A query travelling down the chain, with what it has matched so far.
  typedef struct packed {
    logic   valid;
    entry_t key;
    logic   hit;
    logic   dhit;
    logic   shit;
  } token_t;

  // Events handed from the control and the chain end to the tally.
  typedef struct packed {
    logic done;
    logic hit;
    logic dhit;
    logic shit;
    logic overflow;
    logic finish;
  } tally_evt_t;

  // The pattern -2 counts as a negative sign, so it becomes -1.
  function automatic logic signed [1:0] sign_reduce(input logic [1:0] raw);
    logic signed [1:0] s;
    s = (raw == 2'b10) ? 2'sb11 : $signed(raw);
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/emc_in_if.sv]
`default_nettype none

interface emc_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [15:0]       target;
  logic [7:0]        delay;
  logic signed [1:0] sign;

  modport source (output valid, output op, output target, output delay, output sign,
                  input ready);
  modport sink   (input valid, input op, input target, input delay, input sign,
                  output ready);
endinterface

`default_nettype wire

[rtl/emc_out_if.sv]
`default_nettype none

interface emc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] link_matches;
  logic [15:0] delay_matches;
  logic [15:0] sign_matches;
  logic        ref_overflow;
  logic        count_saturated;

  modport source (output valid, output link_matches, output delay_matches,
                  output sign_matches, output ref_overflow, output count_saturated,
                  input ready);
  modport sink   (input valid, input link_matches, input delay_matches,
                  input sign_matches, input ref_overflow, input count_saturated,
                  output ready);
endinterface

`default_nettype wire

[rtl/edge_match_counter_unit.sv]
`default_nettype none

// Channel   Role    Item
// in_if     sink    op, target, delay, sign (load, query or finish)
// out_if    source  link_matches, delay_matches, sign_matches, ref_overflow,
//                   count_saturated (one item per finish)
//
// A query enters the chain as soon as it is offered and queries may follow back
// to back; each one walks the REF_DEPTH cells, one cell per cycle, and its
// verdict is counted when it leaves the last cell. A load waits until no query
// is left in the chain, and a finish waits for that too and for the result
// register to be free. Reset (rst_n, synchronous) empties the store and the
// counts at once. Back pressure on out_if only holds off finish items.
module edge_match_counter_unit (
  input  logic      clk,
  input  logic      rst_n,
  emc_in_if.sink    in_if,
  emc_out_if.source out_if
);
  import emc_pkg::*;

  // Fill level of the store. Entries sit in cells 0 to ref_count_r-1, the
  // newest in cell 0, since each load shifts the whole store by one cell.
  logic [CNT_W-1:0] ref_count_r, ref_count_nxt;
  // Number of queries still walking the chain.
  logic [CNT_W-1:0] inflight_r, inflight_nxt;

  logic       accept;
  logic       chain_empty;
  logic       out_free;
  logic       is_load, is_query, is_finish;
  logic       store_full;
  logic       shift_en;
  entry_t     new_entry;
  token_t     new_token;
  tally_evt_t evt;

  entry_t entry_chain [REF_DEPTH+1];
  token_t token_chain [REF_DEPTH+1];
  logic   entry_used  [REF_DEPTH];

  assign chain_empty = (inflight_r == '0);
  assign out_free    = !out_if.valid || out_if.ready;
  assign is_load     = (in_if.op == OP_LOAD);
  assign is_query    = (in_if.op == OP_QUERY);
  assign is_finish   = (in_if.op == OP_FINISH);
  assign store_full  = (ref_count_r == CNT_W'(REF_DEPTH));

  // Loads and finishes must not change the store while a query still reads it.
  always_comb begin
    case (in_if.op)
      OP_LOAD:   in_if.ready = chain_empty;
      OP_QUERY:  in_if.ready = 1'b1;
      OP_FINISH: in_if.ready = chain_empty && out_free;
      default:   in_if.ready = 1'b1;
    endcase
  end

  assign accept = in_if.valid && in_if.ready;

  always_comb begin
    new_entry.target = in_if.target;
    new_entry.delay  = in_if.delay;
    new_entry.sign   = sign_reduce(in_if.sign);
  end

  always_comb begin
    new_token       = '0;
    new_token.valid = accept && is_query;
    new_token.key   = new_entry;
  end

  assign shift_en = accept && is_load && !store_full;

  always_comb begin
    ref_count_nxt = ref_count_r;
    if (shift_en) begin
      ref_count_nxt = ref_count_r + 1'b1;
    end else if (accept && is_finish) begin
      ref_count_nxt = '0;
    end
  end

  always_comb begin
    inflight_nxt = inflight_r;
    case ({new_token.valid, token_chain[REF_DEPTH].valid})
      2'b10:   inflight_nxt = inflight_r + 1'b1;
      2'b01:   inflight_nxt = inflight_r - 1'b1;
      default: inflight_nxt = inflight_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_count_r <= '0;
      inflight_r  <= '0;
    end else begin
      ref_count_r <= ref_count_nxt;
      inflight_r  <= inflight_nxt;
    end
  end

  assign entry_chain[0] = new_entry;
  assign token_chain[0] = new_token;

  for (genvar g = 0; g < REF_DEPTH; g++) begin : g_cell
    assign entry_used[g] = (CNT_W'(g) < ref_count_r);

    emc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (shift_en),
      .entry_used (entry_used[g]),
      .entry_in   (entry_chain[g]),
      .token_in   (token_chain[g]),
      .entry_out  (entry_chain[g+1]),
      .token_out  (token_chain[g+1])
    );
  end

  // The token leaving the last cell carries the verdict for its query.
  always_comb begin
    evt.done     = token_chain[REF_DEPTH].valid;
    evt.hit      = token_chain[REF_DEPTH].hit;
    evt.dhit     = token_chain[REF_DEPTH].dhit;
    evt.shit     = token_chain[REF_DEPTH].shit;
    evt.overflow = accept && is_load && store_full;
    evt.finish   = accept && is_finish;
  end

  emc_tally u_tally (
    .clk    (clk),
    .rst_n  (rst_n),
    .evt    (evt),
    .out_if (out_if)
  );

`ifndef NO_ASSERTIONS
  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CNT_W'(REF_DEPTH))
    else $error("more queries in flight than cells");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ref_count_r <= CNT_W'(REF_DEPTH))
    else $error("store fill level beyond depth");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_load) |-> chain_empty)
    else $error("store shifted while a query was in the chain");

  a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_finish) |=> (out_if.valid && ref_count_r == '0))
    else $error("finish did not present a result and clear the store");
`endif

endmodule

`default_nettype wire

[rtl/emc_cell.sv]
`default_nettype none

// One stage of the chain: holds one reference entry and compares the query
// passing through against it.
module emc_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  logic            entry_used,
  input  emc_pkg::entry_t entry_in,
  input  emc_pkg::token_t token_in,
  output emc_pkg::entry_t entry_out,
  output emc_pkg::token_t token_out
);
  import emc_pkg::*;

  entry_t entry_r;
  token_t tok_r;
  token_t tok_nxt;
  logic   tok_valid_r;
  logic   match;

  assign match = entry_used && (entry_r.target == token_in.key.target);

  always_comb begin
    tok_nxt      = token_in;
    tok_nxt.hit  = token_in.hit  | match;
    tok_nxt.dhit = token_in.dhit | (match && (entry_r.delay == token_in.key.delay));
    tok_nxt.shit = token_in.shit | (match && (entry_r.sign == token_in.key.sign));
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry_r <= entry_in;
    end
    tok_r <= tok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= token_in.valid;
    end
  end

  always_comb begin
    token_out       = tok_r;
    token_out.valid = tok_valid_r;
  end

  assign entry_out = entry_r;

endmodule

`default_nettype wire

[rtl/emc_tally.sv]
`default_nettype none

// Saturating match counters, sticky flags and the result register.
module emc_tally (
  input  logic                clk,
  input  logic                rst_n,
  input  emc_pkg::tally_evt_t evt,
  emc_out_if.source           out_if
);
  import emc_pkg::*;

  logic [TOTAL_W-1:0] link_r, link_nxt;
  logic [TOTAL_W-1:0] dly_r, dly_nxt;
  logic [TOTAL_W-1:0] sgn_r, sgn_nxt;
  logic               ovf_r, ovf_nxt;
  logic               sat_r, sat_nxt;
  logic               out_valid_r;
  logic [TOTAL_W-1:0] out_link_r, out_dly_r, out_sgn_r;
  logic               out_ovf_r, out_sat_r;

  always_comb begin
    link_nxt = link_r;
    dly_nxt  = dly_r;
    sgn_nxt  = sgn_r;
    ovf_nxt  = ovf_r | evt.overflow;
    sat_nxt  = sat_r;
    if (evt.done) begin
      if (evt.hit) begin
        if (&link_r) sat_nxt = 1'b1;
        else link_nxt = link_r + 1'b1;
      end
      if (evt.dhit) begin
        if (&dly_r) sat_nxt = 1'b1;
        else dly_nxt = dly_r + 1'b1;
      end
      if (evt.shit) begin
        if (&sgn_r) sat_nxt = 1'b1;
        else sgn_nxt = sgn_r + 1'b1;
      end
    end
    if (evt.finish) begin
      link_nxt = '0;
      dly_nxt  = '0;
      sgn_nxt  = '0;
      ovf_nxt  = 1'b0;
      sat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r      <= '0;
      dly_r       <= '0;
      sgn_r       <= '0;
      ovf_r       <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      link_r <= link_nxt;
      dly_r  <= dly_nxt;
      sgn_r  <= sgn_nxt;
      ovf_r  <= ovf_nxt;
      sat_r  <= sat_nxt;
      if (evt.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt.finish) begin
      out_link_r <= link_r;
      out_dly_r  <= dly_r;
      out_sgn_r  <= sgn_r;
      out_ovf_r  <= ovf_r;
      out_sat_r  <= sat_r;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.link_matches    = out_link_r;
  assign out_if.delay_matches   = out_dly_r;
  assign out_if.sign_matches    = out_sgn_r;
  assign out_if.ref_overflow    = out_ovf_r;
  assign out_if.count_saturated = out_sat_r;

endmodule

`default_nettype wire

[bench/edge_match_counter_unit_tb.sv]
`timescale 1ns / 1ps

// Checks edge_match_counter_unit against a cycle-free software model of the
// match counts. Every item accepted on the input channel is fed to the model;
// every finish item queues the counts the block should report. Results taken
// from the output channel are compared with the oldest queued counts.
module edge_match_counter_unit_tb;
  import emc_pkg::*;

  // The op encoding that the block ignores.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int COUNT_TOP = 65535;
  localparam int MAX_REPORTS = 10;
  // A query walks the REF_DEPTH cells of the chain, so a stray result would
  // show up well within this drain time after the last expected one.
  localparam int DRAIN_CYCLES = 2 * REF_DEPTH + 32;

  typedef struct packed {
    logic [15:0] link;
    logic [15:0] dly;
    logic [15:0] sgn;
    logic        ovf;
    logic        sat;
  } counts_t;

  // Model of the reference store and the three match counts. It keeps the
  // counts that each finish item must produce, oldest first.
  class match_count_tracker;
    logic [15:0]       stored_target [REF_DEPTH];
    logic [7:0]        stored_delay  [REF_DEPTH];
    logic signed [1:0] stored_sign   [REF_DEPTH];
    int                stored_n;
    int                link_cnt;
    int                delay_cnt;
    int                sign_cnt;
    bit                overflow_seen;
    bit                saturation_seen;
    counts_t           pending_counts[$];
    int                mismatches;

    // A raw pattern with the top bit set is negative; -2 is folded onto -1.
    static function logic signed [1:0] fold_sign(logic [1:0] raw);
      if (raw[1]) begin
        return 2'sb11;
      end
      return $signed(raw);
    endfunction

    function int bump_count(int cnt, bit hit);
      if (!hit) begin
        return cnt;
      end
      if (cnt >= COUNT_TOP) begin
        saturation_seen = 1'b1;
        return COUNT_TOP;
      end
      return cnt + 1;
    endfunction

    function void take_item(logic [1:0] op, logic [15:0] tgt, logic [7:0] dly,
                            logic [1:0] sgn_raw);
      logic signed [1:0] s;
      bit                hit;
      bit                dhit;
      bit                shit;
      counts_t           c;
      s = fold_sign(sgn_raw);
      case (op)
        OP_LOAD: begin
          if (stored_n < REF_DEPTH) begin
            stored_target[stored_n] = tgt;
            stored_delay[stored_n]  = dly;
            stored_sign[stored_n]   = s;
            stored_n++;
          end else begin
            overflow_seen = 1'b1;
          end
        end
        OP_QUERY: begin
          hit  = 1'b0;
          dhit = 1'b0;
          shit = 1'b0;
          for (int i = 0; i < stored_n; i++) begin
            if (stored_target[i] == tgt) begin
              hit = 1'b1;
              if (stored_delay[i] == dly) dhit = 1'b1;
              if (stored_sign[i] == s) shit = 1'b1;
            end
          end
          link_cnt  = bump_count(link_cnt, hit);
          delay_cnt = bump_count(delay_cnt, dhit);
          sign_cnt  = bump_count(sign_cnt, shit);
        end
        OP_FINISH: begin
          c.link = link_cnt[15:0];
          c.dly  = delay_cnt[15:0];
          c.sgn  = sign_cnt[15:0];
          c.ovf  = overflow_seen;
          c.sat  = saturation_seen;
          pending_counts.push_back(c);
          stored_n        = 0;
          link_cnt        = 0;
          delay_cnt       = 0;
          sign_cnt        = 0;
          overflow_seen   = 1'b0;
          saturation_seen = 1'b0;
        end
        default: begin
        end
      endcase
    endfunction

    function void report(string what, counts_t want, counts_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s: expected link %0d delay %0d sign %0d ovf %0b sat %0b",
                 $time, what, want.link, want.dly, want.sgn, want.ovf, want.sat);
        $display("%0t: %s:      got link %0d delay %0d sign %0d ovf %0b sat %0b",
                 $time, what, got.link, got.dly, got.sgn, got.ovf, got.sat);
      end
    endfunction

    function void check_counts(counts_t got);
      counts_t want;
      if (pending_counts.size() == 0) begin
        report("result with no finish waiting", '0, got);
        return;
      end
      want = pending_counts.pop_front();
      if (got.link !== want.link || got.dly !== want.dly || got.sgn !== want.sgn ||
          got.ovf !== want.ovf || got.sat !== want.sat) begin
        report("count mismatch", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  emc_in_if  in_ch ();
  emc_out_if out_ch ();

  edge_match_counter_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  match_count_tracker tracker = new();

  // Percent of cycles in which the sender holds back an item and the
  // receiver holds back ready. The stimulus changes them between phases.
  int send_idle_pct = 33;
  int recv_idle_pct = 70;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver stalls at random. Only finish results are affected by it.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Both channels are observed at the clock edge, before anything driven at
  // that edge takes effect. The output side is checked first so that a result
  // never meets an expectation queued in the same cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        tracker.check_counts({out_ch.link_matches, out_ch.delay_matches,
                              out_ch.sign_matches, out_ch.ref_overflow,
                              out_ch.count_saturated});
      end
      if (in_ch.valid && in_ch.ready) begin
        tracker.take_item(in_ch.op, in_ch.target, in_ch.delay, in_ch.sign);
      end
    end
  end

  // Presents one item and returns at the edge where it was taken. Valid is
  // left high afterwards, so back-to-back items never see it dropped and
  // raised within one time step; a gap lowers it in a step of its own.
  task automatic send_item(logic [1:0] op, logic [15:0] tgt, logic [7:0] dly,
                           logic [1:0] sgn);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.target <= tgt;
    in_ch.delay  <= dly;
    in_ch.sign   <= sgn;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Keeps the input quiet until every queued result has been taken.
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_counts.size() != 0);
  endtask

  // Short hand-written sequences: the empty store, the field extremes, the
  // -2 sign pattern, the ignored op code, and a store filled past its depth.
  task automatic directed_items();
    send_item(OP_QUERY, 16'h0000, 8'h00, 2'b00);    // empty store: no match
    send_item(OP_FINISH, 16'h0000, 8'h00, 2'b00);
    send_item(OP_LOAD, 16'h0000, 8'h00, 2'b00);
    send_item(OP_LOAD, 16'hFFFF, 8'hFF, 2'b01);
    send_item(OP_LOAD, 16'hFFFF, 8'h00, 2'b10);     // -2 is stored as -1
    send_item(OP_LOAD, 16'h04D2, 8'h07, 2'b11);
    send_item(OP_QUERY, 16'h0000, 8'h00, 2'b00);    // full match
    send_item(OP_QUERY, 16'hFFFF, 8'hFF, 2'b10);    // sign found on another entry
    send_item(OP_QUERY, 16'hFFFF, 8'h01, 2'b01);    // link and sign only
    send_item(OP_QUERY, 16'h04D2, 8'h07, 2'b10);    // -2 query meets -1 entry
    send_item(OP_UNUSED, 16'hFFFF, 8'hFF, 2'b11);   // ignored
    send_item(OP_QUERY, 16'h10E1, 8'h07, 2'b11);    // unknown target
    send_item(OP_QUERY, 16'h04D2, 8'hFF, 2'b01);    // link only
    send_item(OP_FINISH, 16'hFFFF, 8'hFF, 2'b11);

    // Fill the store and push two more loads into it; they are dropped and
    // flagged. The last stored entry must still be found.
    for (int k = 0; k < REF_DEPTH + 2; k++) begin
      send_item(OP_LOAD, 16'(k), 8'(k), 2'(k));
    end
    send_item(OP_QUERY, 16'(REF_DEPTH - 1), 8'(REF_DEPTH - 1), 2'(REF_DEPTH - 1));
    send_item(OP_QUERY, 16'(REF_DEPTH), 8'(REF_DEPTH), 2'(REF_DEPTH));
    send_item(OP_FINISH, 16'h0000, 8'h00, 2'b00);
  endtask

  // Random vertices: a batch of loads, then queries that mostly pick a loaded
  // edge with its own or a random delay and sign, then a finish. Now and then an
  // ignored op, a late load among the queries, or a missing finish breaks the shape.
  task automatic random_vertices(int n_items);
    logic [15:0] pool_t[$];
    logic [7:0]  pool_d[$];
    logic [1:0]  pool_s[$];
    logic [15:0] base;
    logic [15:0] tgt;
    logic [7:0]  dly;
    logic [1:0]  sgn;
    bit          narrow;
    int          sent;
    int          n_load;
    int          n_query;
    int          j;
    sent = 0;
    while (sent < n_items) begin
      pool_t.delete();
      pool_d.delete();
      pool_s.delete();
      narrow = 1'($urandom_range(1));
      base   = 16'($urandom);
      n_load = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(0, 40);
      for (int k = 0; k < n_load; k++) begin
        tgt = narrow ? 16'(base + $urandom_range(7)) : 16'($urandom);
        if ($urandom_range(19) == 0) tgt = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        dly = 8'($urandom);
        sgn = 2'($urandom);
        pool_t.push_back(tgt);
        pool_d.push_back(dly);
        pool_s.push_back(sgn);
        send_item(OP_LOAD, tgt, dly, sgn);
        sent++;
      end
      n_query = $urandom_range(0, 16);
      for (int k = 0; k < n_query; k++) begin
        if (pool_t.size() != 0 && $urandom_range(99) < 70) begin
          j   = $urandom_range(pool_t.size() - 1);
          tgt = pool_t[j];
          dly = $urandom_range(1) ? pool_d[j] : 8'($urandom);
          sgn = $urandom_range(1) ? pool_s[j] : 2'($urandom);
        end else begin
          tgt = narrow ? 16'(base + $urandom_range(7)) : 16'($urandom);
          dly = 8'($urandom);
          sgn = 2'($urandom);
        end
        send_item(OP_QUERY, tgt, dly, sgn);
        sent++;
        if ($urandom_range(99) < 4) begin
          send_item(OP_UNUSED, 16'($urandom), 8'($urandom), 2'($urandom));
        end
        if ($urandom_range(99) < 4) begin
          tgt = narrow ? 16'(base + $urandom_range(7)) : 16'($urandom);
          dly = 8'($urandom);
          sgn = 2'($urandom);
          pool_t.push_back(tgt);
          pool_d.push_back(dly);
          pool_s.push_back(sgn);
          send_item(OP_LOAD, tgt, dly, sgn);
          sent++;
        end
      end
      if ($urandom_range(99) < 90) begin
        send_item(OP_FINISH, 16'($urandom), 8'($urandom), 2'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.op     <= OP_LOAD;
    in_ch.target <= '0;
    in_ch.delay  <= '0;
    in_ch.sign   <= '0;
    rst_n        <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // The sender idles a third of the time and the receiver most of it.
    send_idle_pct = 33;
    recv_idle_pct = 70;
    directed_items();
    // Let everything drain before the random part starts from a quiet block.
    hold_until_drained();
    random_vertices(175);

    // The roles swap: a slow sender and a mostly ready receiver.
    send_idle_pct = 70;
    recv_idle_pct = 33;
    random_vertices(175);

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_vertices(175);

    in_ch.valid <= 1'b0;
    while (tracker.pending_counts.size() != 0) @(posedge clk);
    // A little longer, so that a result nobody asked for would still be seen.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending_counts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run, where every query stalls a load or a
  // finish for the full chain length.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
